// ===== hw/rtl/ijc_pkg.sv =====
// Shared types, codes and constants for the interrupt and joypad controller.
`default_nettype none

package ijc_pkg;

    typedef enum logic [2:0] {
        CMD_READ     = 3'd0,
        CMD_WRITE    = 3'd1,
        CMD_RAISE    = 3'd2,
        CMD_KEY      = 3'd3,
        CMD_SCAN     = 3'd4,
        CMD_SET_IME  = 3'd5,
        CMD_SET_HALT = 3'd6,
        CMD_SERVICE  = 3'd7
    } cmd_t;

    localparam logic [2:0] REG_P1 = 3'd0;
    localparam logic [2:0] REG_SB = 3'd1;
    localparam logic [2:0] REG_SC = 3'd2;
    localparam logic [2:0] REG_IF = 3'd3;
    localparam logic [2:0] REG_IE = 3'd4;

    localparam int unsigned SRC_COUNT  = 5;
    localparam logic [2:0]  SRC_JOYPAD = 3'd4;

    localparam logic [6:0] VECTOR_BASE = 7'h40;
    localparam logic [7:0] P1_READ_SET = 8'hC0;
    localparam logic [7:0] IF_READ_SET = 8'hE0;
    localparam logic [7:0] SB_READ     = 8'hFF;
    localparam logic [7:0] SC_READ     = 8'hFE;
    localparam logic [7:0] BYTE_ONES   = 8'hFF;
    localparam logic [7:0] SRC_MASK    = 8'h1F;
    localparam logic [1:0] SEL_NONE    = 2'b00;
    localparam logic [1:0] SEL_DIRS    = 2'b01;
    localparam logic [1:0] SEL_BUTTONS = 2'b10;
    localparam logic [1:0] SEL_BOTH    = 2'b11;

    typedef struct packed {
        cmd_t        command;
        logic [2:0]  reg_select;
        logic [7:0]  write_data;
        logic [2:0]  irq_index;
        logic [2:0]  key_index;
        logic        key_pressed;
        logic        flag_value;
        logic [15:0] current_pc;
    } item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        service_taken;
        logic [6:0]  vector_address;
        logic [15:0] return_address;
        logic        halted_now;
        logic        master_enable_now;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ijc_core.sv =====
// Register file, interrupt state and command decode for one request per cycle while fire is high.
`default_nettype none

module ijc_core
    import ijc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    fire,
    input  wire item_t   item,
    output result_t      res
);

    logic [7:0] p1_reg, p1_next;
    logic [7:0] sb_reg, sb_next;
    logic [7:0] sc_reg, sc_next;
    logic [7:0] if_reg, if_next;
    logic [7:0] ie_reg, ie_next;
    logic [7:0] keys_reg, keys_next;
    logic       ime_reg, ime_next;
    logic       halt_reg, halt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg   <= BYTE_ONES;
            sb_reg   <= '0;
            sc_reg   <= '0;
            if_reg   <= '0;
            ie_reg   <= '0;
            keys_reg <= BYTE_ONES;
            ime_reg  <= 1'b0;
            halt_reg <= 1'b0;
        end
        else if (fire)
        begin
            p1_reg   <= p1_next;
            sb_reg   <= sb_next;
            sc_reg   <= sc_next;
            if_reg   <= if_next;
            ie_reg   <= ie_next;
            keys_reg <= keys_next;
            ime_reg  <= ime_next;
            halt_reg <= halt_next;
        end
    end

    logic [7:0] raise_bit;
    logic [7:0] pend;
    logic [2:0] pend_idx;
    logic       pend_any;
    logic [3:0] scan_low;
    logic       scan_fall;

    // lowest pending enabled source wins
    always_comb
    begin
        pend     = if_reg & ie_reg & SRC_MASK;
        pend_idx = '0;
        pend_any = 1'b0;
        for (int i = SRC_COUNT - 1; i >= 0; i--)
        begin
            if (pend[i])
            begin
                pend_idx = 3'(i);
                pend_any = 1'b1;
            end
        end
    end

    always_comb
    begin
        case (p1_reg[5:4])
            SEL_DIRS:    scan_low = keys_reg[7:4];
            SEL_BUTTONS: scan_low = keys_reg[3:0];
            SEL_BOTH:    scan_low = 4'hF;
            default:     scan_low = 4'h0;
        endcase
        scan_fall = |(p1_reg[3:0] & ~scan_low);
    end

    always_comb
    begin
        p1_next   = p1_reg;
        sb_next   = sb_reg;
        sc_next   = sc_reg;
        if_next   = if_reg;
        ie_next   = ie_reg;
        keys_next = keys_reg;
        ime_next  = ime_reg;
        halt_next = halt_reg;
        raise_bit = '0;
        res       = '0;

        unique case (item.command)
            CMD_READ:
            begin
                unique case (item.reg_select)
                    REG_P1:  res.read_data = p1_reg | P1_READ_SET;
                    REG_SB:  res.read_data = SB_READ;
                    REG_SC:  res.read_data = SC_READ;
                    REG_IF:  res.read_data = if_reg | IF_READ_SET;
                    REG_IE:  res.read_data = ie_reg;
                    default: res.read_data = BYTE_ONES;
                endcase
            end
            CMD_WRITE:
            begin
                unique case (item.reg_select)
                    REG_P1:  p1_next = item.write_data;
                    REG_SB:  sb_next = item.write_data;
                    REG_SC:  sc_next = item.write_data;
                    REG_IF:  if_next = item.write_data;
                    REG_IE:  ie_next = item.write_data;
                    default: ;
                endcase
            end
            CMD_RAISE:
            begin
                if (item.irq_index < 3'(SRC_COUNT))
                begin
                    raise_bit = 8'd1 << item.irq_index;
                end
            end
            CMD_KEY:
            begin
                keys_next[item.key_index] = ~item.key_pressed;
            end
            CMD_SCAN:
            begin
                p1_next = {p1_reg[7:4], scan_low};
                if (scan_fall)
                begin
                    raise_bit = 8'd1 << SRC_JOYPAD;
                end
            end
            CMD_SET_IME:
            begin
                ime_next = item.flag_value;
            end
            CMD_SET_HALT:
            begin
                halt_next = item.flag_value;
            end
            CMD_SERVICE:
            begin
                if (ime_reg && pend_any)
                begin
                    if_next[pend_idx]  = 1'b0;
                    ime_next           = 1'b0;
                    res.service_taken  = 1'b1;
                    res.vector_address = VECTOR_BASE + {1'b0, pend_idx, 3'b000};
                    res.return_address = item.current_pc;
                end
            end
        endcase

        // wake from halt when the raised source is enabled
        if (|(raise_bit & ie_reg))
        begin
            halt_next = 1'b0;
        end
        if_next = if_next | raise_bit;

        res.halted_now        = halt_next;
        res.master_enable_now = ime_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/interrupt_and_joypad_controller.sv =====
// Top level: input request register, command core and output result register.
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------------
//  in      | in_valid / in_ready | command, reg_select, write_data, irq_index,
//          |                     | key_index, key_pressed, flag_value, current_pc
//  out     | out_valid/out_ready | read_data, service_taken, vector_address,
//          |                     | return_address, halted_now, master_enable_now
//
// One request per cycle unless stalled; input register, then result register.
// State updates in the cycle a request moves from the input register to the result
// register, so each request sees the state left by the one before it.
// Reset: P1 and key lines all ones, everything else clear, both stages empty.
// A stalled result holds both stages; in_ready drops only when both are full.
`default_nettype none

module interrupt_and_joypad_controller
    import ijc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  command,
    input  wire logic [2:0]  reg_select,
    input  wire logic [7:0]  write_data,
    input  wire logic [2:0]  irq_index,
    input  wire logic [2:0]  key_index,
    input  wire logic        key_pressed,
    input  wire logic        flag_value,
    input  wire logic [15:0] current_pc,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       read_data,
    output logic             service_taken,
    output logic [6:0]       vector_address,
    output logic [15:0]      return_address,
    output logic             halted_now,
    output logic             master_enable_now
);

    logic    in_valid_reg;
    item_t   item_reg;
    logic    out_valid_reg;
    result_t res_reg;
    result_t res_next;
    logic    advance;
    logic    fire;
    logic    in_fire;

    assign advance  = !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= '{
                command:     cmd_t'(command),
                reg_select:  reg_select,
                write_data:  write_data,
                irq_index:   irq_index,
                key_index:   key_index,
                key_pressed: key_pressed,
                flag_value:  flag_value,
                current_pc:  current_pc
            };
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    ijc_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .res   (res_next)
    );

    assign out_valid         = out_valid_reg;
    assign read_data         = res_reg.read_data;
    assign service_taken     = res_reg.service_taken;
    assign vector_address    = res_reg.vector_address;
    assign return_address    = res_reg.return_address;
    assign halted_now        = res_reg.halted_now;
    assign master_enable_now = res_reg.master_enable_now;

    // a dispatched interrupt always drops the master enable and lands on a vector slot
    a_taken_vector: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && service_taken |->
            !master_enable_now && vector_address[6] && vector_address[2:0] == 3'b000)
        else $error("service result with bad vector or master enable");

    // no dispatch means no vector and no return address
    a_idle_vector: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !service_taken |-> vector_address == 7'd0 && return_address == 16'd0)
        else $error("vector reported without dispatch");

    // a held request stays in the input register until it can move on
    a_hold_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && out_valid_reg)
        else $error("pending request lost under stall");

endmodule

`default_nettype wire
